/* rtl/core/utrd_pkg.sv */
// Package for the unsigned to radix digits core.
// Holds the sizes, the sequencer state type, the divider request and response
// structs and the digit glyph function. No dependencies.
`default_nettype none

package utrd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CHUNK_BITS = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_BITS   = DIV_STEPS * CHUNK_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int RADIX_W    = 8;

  localparam logic [RADIX_W-1:0] RadixMin = 8'd2;
  localparam logic [RADIX_W-1:0] RadixMax = 8'd36;
  localparam logic [DIGIT_W-1:0] DigitMax = 6'd35;
  localparam logic [CHAR_W-1:0]  CharNul  = 7'h00;
  localparam logic [CHAR_W-1:0]  CharZero = 7'h30;
  localparam logic [CHAR_W-1:0]  CharA    = 7'h61;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT,
    S_TERM
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIGIT_W-1:0]    radix;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dc;
    dc = (d > DigitMax) ? DigitMax : d;
    if (dc < 6'd10) begin
      return CharZero + {1'b0, dc};
    end
    return CharA + {1'b0, dc} - 7'd10;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/utrd_if.sv */
// Stream interfaces for the unsigned to radix digits core.
// Input channel carries number and radix, result channel a character and last.
// Depends on utrd_pkg.
`default_nettype none

interface utrd_in_if;
  import utrd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] number;
  logic [RADIX_W-1:0]    radix;
  modport source (output valid, output number, output radix, input ready);
  modport sink (input valid, input number, input radix, output ready);
endinterface

interface utrd_out_if;
  import utrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/unsigned_to_radix_digits_core.sv */
// Unsigned to radix digits core: one input transfer gives D digit transfers,
// most significant first, then a NUL transfer with last set.
// Each digit takes one pass through the shared divider; the digits are stored
// and then sent out, the output side waiting on out ready.
// A base outside 2..36 gives the NUL transfer only. in ready is low while busy.
// Synchronous active-low reset clears the sequencer; the digit store is not reset.
`default_nettype none

module unsigned_to_radix_digits_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  utrd_in_if.sink    in_ch,
  utrd_out_if.source out_ch
);
  import utrd_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   emit_r, emit_nxt;
  logic [DIGIT_W-1:0] radix_r, radix_nxt;
  logic [DIGIT_W-1:0] store_r [VALUE_BITS];

  div_req_t req;
  div_rsp_t rsp;

  logic in_xfer;
  logic out_xfer;
  logic radix_ok;
  logic q_zero;
  logic [CNT_W-1:0] emit_idx;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign radix_ok = (in_ch.radix >= RadixMin) && (in_ch.radix <= RadixMax);
  assign q_zero   = (rsp.quotient == '0);
  assign emit_idx = emit_r - 1'b1;

  utrd_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    emit_nxt  = emit_r;
    radix_nxt = radix_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (radix_ok) begin
            state_nxt = S_DIV;
            count_nxt = '0;
            radix_nxt = in_ch.radix[DIGIT_W-1:0];
          end else begin
            state_nxt = S_TERM;
          end
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          count_nxt = count_r + 1'b1;
          if (q_zero) begin
            state_nxt = S_EMIT;
            emit_nxt  = count_r + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          emit_nxt = emit_r - 1'b1;
          if (emit_r == CNT_W'(1)) begin
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (out_xfer) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    out_ch.character = CharNul;
    out_ch.last      = 1'b0;
    req.start        = 1'b0;
    req.dividend     = in_ch.number;
    req.radix        = in_ch.radix[DIGIT_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        req.start   = in_ch.valid && radix_ok;
      end
      S_DIV: begin
        req.dividend = rsp.quotient;
        req.radix    = radix_r;
        req.start    = rsp.done && !q_zero;
      end
      S_EMIT: begin
        out_ch.valid     = 1'b1;
        out_ch.character = digit_glyph(store_r[emit_idx[IDX_W-1:0]]);
      end
      S_TERM: begin
        out_ch.valid = 1'b1;
        out_ch.last  = 1'b1;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      emit_r  <= emit_nxt;
    end
    radix_r <= radix_nxt;
    if (state_r == S_DIV && rsp.done) begin
      store_r[count_r[IDX_W-1:0]] <= rsp.remainder;
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (emit_r != '0) && (emit_r <= count_r))
    else $error("digit index out of range");

  a_term_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_xfer && emit_r == CNT_W'(1)) |=> out_ch.last)
    else $error("terminator did not follow the last digit");
`endif

endmodule

`default_nettype wire

/* rtl/core/utrd_div_unit.sv */
// Iterative restoring divider: value by a radix of up to 63, CHUNK_BITS
// quotient bits per cycle while busy, done pulse after the last chunk.
// Depends on utrd_pkg.
`default_nettype none

module utrd_div_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire utrd_pkg::div_req_t req,
  output utrd_pkg::div_rsp_t      rsp
);
  import utrd_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [PAD_BITS-1:0]   work_r, work_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [DIGIT_W-1:0]    radix_r, radix_nxt;

  logic [DIGIT_W:0]      part;
  logic [CHUNK_BITS-1:0] qbits;
  logic [CHUNK_BITS-1:0] chunk;

  always_comb begin
    chunk = work_r[PAD_BITS-1 -: CHUNK_BITS];
    part  = {1'b0, rem_r};
    qbits = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      part = {part[DIGIT_W-1:0], chunk[i]};
      if (part >= {1'b0, radix_r}) begin
        part     = part - {1'b0, radix_r};
        qbits[i] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = STEP_W'(DIV_STEPS);
      work_nxt  = PAD_BITS'(req.dividend);
      rem_nxt   = '0;
      radix_nxt = req.radix;
    end else if (busy_r) begin
      work_nxt = (PAD_BITS > CHUNK_BITS) ?
                 {work_r[PAD_BITS-CHUNK_BITS-1:0], qbits} : PAD_BITS'(qbits);
      rem_nxt  = part[DIGIT_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = work_r[VALUE_BITS-1:0];
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

/* bench/unsigned_to_radix_digits_core_test.sv */
// Testbench for unsigned_to_radix_digits_core: directed rows, then random items,
// with every result transfer checked against expected text or a built-in digit predictor.
// Depends on utrd_pkg, utrd_if.sv and the core.
`timescale 1ns / 100ps

module unsigned_to_radix_digits_core_test;
  import utrd_pkg::*;

  localparam int RANDOM_ITEMS = 390;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int TAIL_CYCLES  = 250;

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last;
  } glyph_t;

  typedef struct {
    logic [VALUE_BITS-1:0] number;
    logic [RADIX_W-1:0]    radix;
    bit                    typed;
    string                 text;
  } row_t;

  logic clk;
  logic rst_n;

  utrd_in_if  in_ch ();
  utrd_out_if out_ch ();

  unsigned_to_radix_digits_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glyph_t pending_glyphs[$];
  int     error_count;
  int     cycle_count;
  int     send_run;
  row_t   directed_rows[$];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** unsigned_to_radix_digits_core: FAILED **");
      $finish;
    end
  end

  // Digits of num in base rad, most significant first, then NUL with last set.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] num,
                                         input logic [RADIX_W-1:0] rad);
    logic [VALUE_BITS-1:0] q;
    logic [DIGIT_W-1:0]    rems[$];
    logic [DIGIT_W-1:0]    d;
    glyph_t                g;
    if (rad >= RadixMin && rad <= RadixMax) begin
      q = num;
      do begin
        rems.push_front(DIGIT_W'(q % rad));
        q = q / rad;
      end while (q != '0);
      foreach (rems[i]) begin
        d = (rems[i] > DigitMax) ? DigitMax : rems[i];
        g.character = (d < 10) ? CharZero + CHAR_W'(d) : CharA + CHAR_W'(d) - CHAR_W'(10);
        g.last = 1'b0;
        pending_glyphs.push_back(g);
      end
    end
    g.character = CharNul;
    g.last = 1'b1;
    pending_glyphs.push_back(g);
  endfunction

  function automatic int sender_gap();
    int r;
    if (send_run > 0) begin
      send_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      send_run = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic [VALUE_BITS-1:0] num, input logic [RADIX_W-1:0] rad,
                           input bit typed, input string text);
    int     gap;
    byte    c;
    glyph_t g;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.number <= num;
    in_ch.radix  <= rad;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        c = text[i];
        g.character = c[CHAR_W-1:0];
        g.last = 1'b0;
        pending_glyphs.push_back(g);
      end
      g.character = CharNul;
      g.last = 1'b1;
      pending_glyphs.push_back(g);
    end else begin
      predict_digits(num, rad);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_item();
    logic [VALUE_BITS-1:0] num;
    logic [RADIX_W-1:0]    rad;
    longint unsigned       acc;
    int                    r;
    int                    k;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      rad = ($urandom_range(0, 2) == 0) ? RADIX_W'($urandom_range(0, 1))
                                        : RADIX_W'($urandom_range(37, 255));
    end else if (r < 25) begin
      rad = RADIX_W'($urandom_range(2, 4));
    end else begin
      rad = RADIX_W'($urandom_range(2, 36));
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      num = $urandom;
    end else if (r < 60) begin
      num = $urandom_range(0, 100);
    end else if (r < 80 && rad >= RadixMin) begin
      // powers of the base and their neighbors: digit count boundaries
      acc = 1;
      k = $urandom_range(0, 31);
      repeat (k) begin
        if (acc * longint'(rad) <= 64'hFFFF_FFFF) acc = acc * longint'(rad);
      end
      num = VALUE_BITS'(acc + longint'($urandom_range(0, 2)) - 1);
    end else if (r < 90) begin
      num = (32'h1 << $urandom_range(0, 31)) - VALUE_BITS'($urandom_range(0, 1));
    end else begin
      num = $urandom >> $urandom_range(0, 31);
    end
    send_item(num, rad, 1'b0, "");
  endtask

  initial begin : result_pacing
    int stall_left;
    int open_left;
    int pick;
    stall_left = 0;
    open_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (open_left > 0) begin
          open_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 8) open_left = $urandom_range(20, 100);
          else if (pick < 12) stall_left = $urandom_range(15, 60);
          else if (pick < 45) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    glyph_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_glyphs.size() == 0) begin
        $error("unexpected transfer: character %h last %b", out_ch.character, out_ch.last);
        error_count++;
      end else begin
        want = pending_glyphs.pop_front();
        if (out_ch.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, out_ch.character);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    send_run     = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.number = '0;
    in_ch.radix  = '0;

    directed_rows = '{
      '{32'd0,          8'd10,  1'b1, "0"},
      '{32'd0,          8'd2,   1'b1, "0"},
      '{32'hFFFF_FFFF,  8'd16,  1'b1, "ffffffff"},
      '{32'hFFFF_FFFF,  8'd2,   1'b1, "11111111111111111111111111111111"},
      '{32'h8000_0000,  8'd2,   1'b1, "10000000000000000000000000000000"},
      '{32'hFFFF_FFFF,  8'd36,  1'b1, "1z141z3"},
      '{32'hFFFF_FFFF,  8'd10,  1'b1, "4294967295"},
      '{32'd35,         8'd36,  1'b1, "z"},
      '{32'd36,         8'd36,  1'b1, "10"},
      '{32'd1,          8'd2,   1'b1, "1"},
      '{32'd255,        8'd16,  1'b1, "ff"},
      '{32'd12345,      8'd0,   1'b1, ""},
      '{32'd12345,      8'd1,   1'b1, ""},
      '{32'd12345,      8'd37,  1'b1, ""},
      '{32'd12345,      8'd255, 1'b1, ""},
      '{32'hFFFF_FFFF,  8'd128, 1'b1, ""},
      '{32'd0,          8'd255, 1'b1, ""},
      '{32'hDEAD_BEEF,  8'd7,   1'b0, ""},
      '{32'd1000,       8'd3,   1'b0, ""},
      '{32'h7FFF_FFFF,  8'd35,  1'b0, ""},
      '{32'h1234_5678,  8'd8,   1'b0, ""},
      '{32'hCAFE_F00D,  8'd36,  1'b0, ""},
      '{32'd99,         8'd9,   1'b0, ""},
      '{32'h5555_5555,  8'd4,   1'b0, ""}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].number, directed_rows[i].radix,
                directed_rows[i].typed, directed_rows[i].text);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      random_item();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** unsigned_to_radix_digits_core: PASSED **");
    end else begin
      $display("** unsigned_to_radix_digits_core: FAILED **");
    end
    $finish;
  end

endmodule
